### sv/srpc_pkg.sv
// srpc_pkg: shared types, codes and constants of the servo record and playback controller
// no dependencies; imported by the controller, its slot store and its port checker

package srpc_pkg;

    // operating mode, one-hot
    typedef enum logic [2:0] {
        MODE_TEACH  = 3'b001,
        MODE_PLAY   = 3'b010,
        MODE_REMOTE = 3'b100
    } mode_t;

    // mode codes as shown on the result word
    localparam logic [1:0] MODE_CODE_MANUAL = 2'd0;
    localparam logic [1:0] MODE_CODE_PLAY   = 2'd1;
    localparam logic [1:0] MODE_CODE_REMOTE = 2'd2;

    // configuration register indexes
    localparam int          CFG_INDEX_W     = 3;
    localparam logic [2:0] CFG_DEBOUNCE    = 3'd0;
    localparam logic [2:0] CFG_PLAY_STEP   = 3'd1;
    localparam logic [2:0] CFG_BLINK_SLOW  = 3'd2;
    localparam logic [2:0] CFG_BLINK_FAST  = 3'd3;
    localparam logic [2:0] CFG_PULSE_MIN   = 3'd4;
    localparam logic [2:0] CFG_PULSE_SPAN  = 3'd5;
    localparam int          CFG_DATA_W      = 16;

    // register reset values and the pulse ceiling
    localparam logic [15:0] DEBOUNCE_RST   = 16'd50;
    localparam logic [15:0] PLAY_STEP_RST  = 16'd1500;
    localparam logic [15:0] BLINK_SLOW_RST = 16'd500;
    localparam logic [15:0] BLINK_FAST_RST = 16'd100;
    localparam logic [10:0] PULSE_MIN_RST  = 11'd1000;
    localparam logic [9:0]  PULSE_SPAN_RST = 10'd1000;
    localparam logic [10:0] SERVO_RST_US   = 11'd1500;
    localparam logic [10:0] PULSE_MAX_US   = 11'd2047;

    // event flag bits
    localparam int FLAG_MODE    = 0;
    localparam int FLAG_SAVED   = 1;
    localparam int FLAG_SLOT    = 2;
    localparam int FLAG_PLAYED  = 3;
    localparam int FLAG_RESTART = 4;
    localparam int FLAGS_W      = 5;

    // button order
    localparam int BTN_MODE = 0;
    localparam int BTN_SAVE = 1;
    localparam int BTN_SLOT = 2;

    // word layouts
    localparam int SERVO_W       = 11;
    localparam int ADC_W         = 10;
    localparam int ADC_CHANNELS  = 4;
    localparam int IN_ADC_LSB    = 3;
    localparam int IN_TDATA_W    = 48;
    localparam int OUT_LED_BIT   = 44;
    localparam int OUT_MODE_LSB  = 45;
    localparam int OUT_SEL_LSB   = 47;
    localparam int OUT_NEXT_LSB  = 50;
    localparam int OUT_FLAGS_LSB = 53;
    localparam int OUT_TDATA_W   = 64;

    function automatic logic [1:0] mode_code(input mode_t m);
        logic [1:0] c;
        unique case (m)
            MODE_TEACH:  c = MODE_CODE_MANUAL;
            MODE_PLAY:   c = MODE_CODE_PLAY;
            MODE_REMOTE: c = MODE_CODE_REMOTE;
            default:     c = MODE_CODE_MANUAL;
        endcase
        return c;
    endfunction

    // min + raw * span / 1023, saturated at the 11-bit maximum
    // the quotient uses (p + (p >> 10) + 1) >> 10, exact for p below 1023 * 1024
    function automatic logic [10:0] pulse_map(input logic [9:0] raw,
                                              input logic [10:0] pmin,
                                              input logic [9:0] span);
        logic [19:0] prod;
        logic [19:0] acc;
        logic [11:0] us;
        prod = raw * span;
        acc  = prod + {10'd0, prod[19:10]} + 20'd1;
        us   = {1'b0, pmin} + {2'b00, acc[19:10]};
        return us[11] ? PULSE_MAX_US : us[10:0];
    endfunction

endpackage

### sv/srpc_slot_store.sv
// srpc_slot_store: slot store, one row of servo positions per slot, with row valid bits
// depends on srpc_pkg; used by servo_record_playback_controller_unit

module srpc_slot_store #(
    parameter int SLOT_COUNT = 8,
    parameter int ROW_W      = 44
) (
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  logic                                        wr_en,
    input  logic [((SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1)-1:0] wr_row,
    input  logic [ROW_W-1:0]                            wr_data,
    input  logic [((SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1)-1:0] rd_row,
    output logic [ROW_W-1:0]                            play_data,
    output logic [ROW_W-1:0]                            zero_data
);
    import srpc_pkg::*;

    localparam int SLOT_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

    logic [ROW_W-1:0]      mem [SLOT_COUNT];
    logic [ROW_W-1:0]      rd_play_reg;
    logic [ROW_W-1:0]      rd_zero_reg;
    logic [ROW_W-1:0]      fwd_data_reg;
    logic                  fwd_play_reg;
    logic                  fwd_zero_reg;
    logic [SLOT_W-1:0]     rd_row_reg;
    logic [SLOT_COUNT-1:0] valid_reg;

    // storage, two registered reads: the addressed row and row zero
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_row] <= wr_data;
        end
        rd_play_reg  <= mem[rd_row];
        rd_zero_reg  <= mem[SLOT_W'(0)];
        fwd_data_reg <= wr_data;
    end

    // write-through bypass and row valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_play_reg <= 1'b0;
            fwd_zero_reg <= 1'b0;
            rd_row_reg   <= '0;
            valid_reg    <= '0;
        end
        else
        begin
            fwd_play_reg <= wr_en && (wr_row == rd_row);
            fwd_zero_reg <= wr_en && (wr_row == SLOT_W'(0));
            rd_row_reg   <= rd_row;
            if (wr_en)
            begin
                valid_reg[wr_row] <= 1'b1;
            end
        end
    end

    assign play_data = !valid_reg[rd_row_reg] ? '0 :
                       (fwd_play_reg ? fwd_data_reg : rd_play_reg);
    assign zero_data = !valid_reg[0] ? '0 :
                       (fwd_zero_reg ? fwd_data_reg : rd_zero_reg);

endmodule

### sv/servo_record_playback_controller_unit.sv
// servo_record_playback_controller_unit: top level, tick processing, mode control, result register
// depends on srpc_pkg and srpc_slot_store
//
//  channel   | direction | handshake        | contents
//  ----------+-----------+------------------+-----------------------------------------------
//  s_ (tick) | in        | s_tvalid/s_tready | buttons, adc readings in tdata, adc_valid in tuser
//  m_ (state)| out       | m_tvalid/m_tready | servo widths, led, mode, slots, event flags
//  cfg_      | in        | cfg_wr_en         | register index and write data, no read-back
//
// one tick word is taken per clock while s_tready is high; its result sits in the output
// register the next cycle; slot store reads are registered, and the row for the
// current playback slot and row zero are fetched ahead so a playback step needs no wait
// s_tready drops only while a result is held and m_tready is low
// reset clears the store at once through per-slot valid bits; no clearing pass is run

module servo_record_playback_controller_unit #(
    parameter int SLOT_COUNT  = 8,
    parameter int SERVO_COUNT = 4
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // tick words
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // mode_button_level, save_button_level, slot_button_level, adc_ch0..adc_ch3, zero fill
    input  logic [srpc_pkg::IN_TDATA_W-1:0]   s_tdata,
    // adc_valid
    input  logic                              s_tuser,
    // result words
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // servo0_us..servo3_us, led_on, mode_now, selected_slot, next_play_slot, event_flags,
    // zero fill
    output logic [srpc_pkg::OUT_TDATA_W-1:0]  m_tdata,
    // configuration
    input  logic                              cfg_wr_en,
    input  logic [srpc_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [srpc_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import srpc_pkg::*;

    localparam int SLOT_W    = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int ROW_W     = SERVO_COUNT * SERVO_W;
    localparam int ADC_LANES = (SERVO_COUNT < ADC_CHANNELS) ? SERVO_COUNT : ADC_CHANNELS;
    localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(SLOT_COUNT - 1);

    // configuration registers
    logic [15:0] debounce_reg;
    logic [15:0] play_step_ms_reg;
    logic [15:0] blink_slow_reg;
    logic [15:0] blink_fast_reg;
    logic [10:0] pulse_min_reg;
    logic [9:0]  pulse_span_reg;

    // controller state
    logic [31:0]        tick_reg,        tick_next;
    logic [2:0]         btn_level_reg,   btn_level_next;
    logic [31:0]        btn_change_reg [3];
    logic [31:0]        btn_change_next [3];
    logic               led_phase_reg,   led_phase_next;
    logic               led_drive_reg,   led_drive_next;
    logic [31:0]        led_toggle_reg,  led_toggle_next;
    mode_t              mode_reg,        mode_next;
    logic [SLOT_W-1:0]  save_slot_reg,   save_slot_next;
    logic [SLOT_W-1:0]  play_slot_reg,   play_slot_next;
    logic [31:0]        play_step_reg,   play_step_next;
    logic [SERVO_W-1:0] servo_reg [SERVO_COUNT];
    logic [SERVO_W-1:0] servo_next [SERVO_COUNT];

    // result register
    logic                   out_valid_reg;
    logic [OUT_TDATA_W-1:0] out_data_reg;
    logic [OUT_TDATA_W-1:0] out_data_next;

    // item decode and working signals
    logic               accept;
    logic [2:0]         btn_in;
    logic [ADC_W-1:0]   adc [ADC_CHANNELS];
    logic [31:0]        now;
    logic [2:0]         btn_change;
    logic [2:0]         btn_press;
    logic [15:0]        blink_period;
    logic               entering_play;
    logic [FLAGS_W-1:0] flags;
    logic               store_wr_en;
    logic [ROW_W-1:0]   store_wr_data;
    logic [SLOT_W-1:0]  store_rd_row;
    logic [ROW_W-1:0]   row_play;
    logic [ROW_W-1:0]   row_zero;
    logic [ROW_W-1:0]   row_load;
    logic [SERVO_W-1:0] out_servo [ADC_CHANNELS];
    logic [31:0]        save_slot_wide;
    logic [31:0]        play_slot_wide;

    function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] s);
        return (s == SLOT_LAST) ? '0 : (s + SLOT_W'(1));
    endfunction

    assign accept   = s_tvalid && s_tready;
    assign s_tready = !out_valid_reg || m_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // tick word fields
    assign btn_in = s_tdata[2:0];
    for (genvar c = 0; c < ADC_CHANNELS; c++)
    begin : g_adc
        assign adc[c] = s_tdata[IN_ADC_LSB + c * ADC_W +: ADC_W];
    end

    assign now = tick_reg + 32'd1;

    // a level change is taken once the debounce window has run; a press is a change to low
    for (genvar b = 0; b < 3; b++)
    begin : g_btn
        assign btn_change[b] = (btn_in[b] != btn_level_reg[b])
                            && ((now - btn_change_reg[b]) >= {16'd0, debounce_reg});
        assign btn_press[b]  = btn_change[b] && !btn_in[b];
    end

    assign blink_period = (mode_reg == MODE_PLAY) ? blink_slow_reg : blink_fast_reg;

    // entering playback restarts at slot zero, so the prefetched row zero is used
    assign row_load = entering_play ? row_zero : row_play;

    // ------------------------------------------------------------------
    // tick processing: led, mode button, then the work of the new mode
    // ------------------------------------------------------------------
    always_comb
    begin
        tick_next       = now;
        btn_level_next  = btn_level_reg;
        btn_change_next = btn_change_reg;
        led_phase_next  = led_phase_reg;
        led_drive_next  = led_drive_reg;
        led_toggle_next = led_toggle_reg;
        mode_next       = mode_reg;
        save_slot_next  = save_slot_reg;
        play_slot_next  = play_slot_reg;
        play_step_next  = play_step_reg;
        servo_next      = servo_reg;
        flags           = '0;
        entering_play   = 1'b0;
        store_wr_en     = 1'b0;

        // status led for the mode held at the start of the tick
        unique case (mode_reg) inside
            MODE_TEACH:
            begin
                led_drive_next = 1'b1;
            end
            MODE_PLAY, MODE_REMOTE:
            begin
                if ((now - led_toggle_reg) >= {16'd0, blink_period})
                begin
                    led_phase_next  = !led_phase_reg;
                    led_drive_next  = !led_phase_reg;
                    led_toggle_next = now;
                end
            end
            default:
            begin
                led_drive_next = led_drive_reg;
            end
        endcase

        // mode button, always polled
        if (btn_change[BTN_MODE])
        begin
            btn_level_next[BTN_MODE]  = btn_in[BTN_MODE];
            btn_change_next[BTN_MODE] = now;
        end
        if (btn_press[BTN_MODE])
        begin
            flags[FLAG_MODE] = 1'b1;
            unique case (mode_reg)
                MODE_TEACH:
                begin
                    mode_next      = MODE_PLAY;
                    play_slot_next = '0;
                    entering_play  = 1'b1;
                end
                MODE_PLAY:   mode_next = MODE_REMOTE;
                MODE_REMOTE: mode_next = MODE_TEACH;
                default:     mode_next = MODE_TEACH;
            endcase
        end

        unique case (mode_next)
            MODE_TEACH:
            begin
                // follow the pots when a fresh set of readings is present
                if (s_tuser)
                begin
                    for (int i = 0; i < ADC_LANES; i++)
                    begin
                        servo_next[i] = pulse_map(adc[i], pulse_min_reg, pulse_span_reg);
                    end
                end
                if (btn_change[BTN_SAVE])
                begin
                    btn_level_next[BTN_SAVE]  = btn_in[BTN_SAVE];
                    btn_change_next[BTN_SAVE] = now;
                end
                if (btn_press[BTN_SAVE])
                begin
                    store_wr_en       = 1'b1;
                    flags[FLAG_SAVED] = 1'b1;
                end
                if (btn_change[BTN_SLOT])
                begin
                    btn_level_next[BTN_SLOT]  = btn_in[BTN_SLOT];
                    btn_change_next[BTN_SLOT] = now;
                end
                if (btn_press[BTN_SLOT])
                begin
                    save_slot_next   = slot_inc(save_slot_reg);
                    flags[FLAG_SLOT] = 1'b1;
                end
            end
            MODE_PLAY:
            begin
                // step to the next stored row when the interval has run
                if ((now - play_step_reg) >= {16'd0, play_step_ms_reg})
                begin
                    for (int i = 0; i < SERVO_COUNT; i++)
                    begin
                        servo_next[i] = row_load[i * SERVO_W +: SERVO_W];
                    end
                    play_slot_next     = slot_inc(play_slot_next);
                    play_step_next     = now;
                    flags[FLAG_PLAYED] = 1'b1;
                end
                if (btn_change[BTN_SLOT])
                begin
                    btn_level_next[BTN_SLOT]  = btn_in[BTN_SLOT];
                    btn_change_next[BTN_SLOT] = now;
                end
                if (btn_press[BTN_SLOT])
                begin
                    play_slot_next      = '0;
                    play_step_next      = now;
                    flags[FLAG_RESTART] = 1'b1;
                end
            end
            MODE_REMOTE:
            begin
                // positions held
                servo_next = servo_reg;
            end
            default:
            begin
                servo_next = servo_reg;
            end
        endcase
    end

    // row written on save holds the positions after this tick's readings
    always_comb
    begin
        store_wr_data = '0;
        for (int i = 0; i < SERVO_COUNT; i++)
        begin
            store_wr_data[i * SERVO_W +: SERVO_W] = servo_next[i];
        end
    end

    // read address follows the playback slot the next tick will use
    assign store_rd_row = accept ? play_slot_next : play_slot_reg;

    srpc_slot_store #(
        .SLOT_COUNT (SLOT_COUNT),
        .ROW_W      (ROW_W)
    ) u_store (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_en     (accept && store_wr_en),
        .wr_row    (save_slot_reg),
        .wr_data   (store_wr_data),
        .rd_row    (store_rd_row),
        .play_data (row_play),
        .zero_data (row_zero)
    );

    // result word, servos that do not exist read as zero
    for (genvar g = 0; g < ADC_CHANNELS; g++)
    begin : g_out
        if (g < SERVO_COUNT)
        begin : g_live
            assign out_servo[g] = servo_next[g];
        end
        else
        begin : g_none
            assign out_servo[g] = '0;
        end
    end

    assign save_slot_wide = 32'(save_slot_next);
    assign play_slot_wide = 32'(play_slot_next);

    always_comb
    begin
        out_data_next = '0;
        for (int i = 0; i < ADC_CHANNELS; i++)
        begin
            out_data_next[i * SERVO_W +: SERVO_W] = out_servo[i];
        end
        out_data_next[OUT_LED_BIT]              = led_drive_next;
        out_data_next[OUT_MODE_LSB +: 2]        = mode_code(mode_next);
        out_data_next[OUT_SEL_LSB +: 3]         = save_slot_wide[2:0];
        out_data_next[OUT_NEXT_LSB +: 3]        = play_slot_wide[2:0];
        out_data_next[OUT_FLAGS_LSB +: FLAGS_W] = flags;
    end

    // ------------------------------------------------------------------
    // registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_reg     <= DEBOUNCE_RST;
            play_step_ms_reg <= PLAY_STEP_RST;
            blink_slow_reg   <= BLINK_SLOW_RST;
            blink_fast_reg   <= BLINK_FAST_RST;
            pulse_min_reg    <= PULSE_MIN_RST;
            pulse_span_reg   <= PULSE_SPAN_RST;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_DEBOUNCE:   debounce_reg     <= cfg_data;
                CFG_PLAY_STEP:  play_step_ms_reg <= cfg_data;
                CFG_BLINK_SLOW: blink_slow_reg   <= cfg_data;
                CFG_BLINK_FAST: blink_fast_reg   <= cfg_data;
                CFG_PULSE_MIN:  pulse_min_reg    <= cfg_data[10:0];
                CFG_PULSE_SPAN: pulse_span_reg   <= cfg_data[9:0];
                default:        debounce_reg     <= debounce_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_reg       <= '0;
            btn_level_reg  <= 3'b111;
            for (int b = 0; b < 3; b++)
            begin
                btn_change_reg[b] <= '0;
            end
            led_phase_reg  <= 1'b0;
            led_drive_reg  <= 1'b1;
            led_toggle_reg <= '0;
            mode_reg       <= MODE_TEACH;
            save_slot_reg  <= '0;
            play_slot_reg  <= '0;
            play_step_reg  <= '0;
            for (int i = 0; i < SERVO_COUNT; i++)
            begin
                servo_reg[i] <= SERVO_RST_US;
            end
        end
        else if (accept)
        begin
            tick_reg       <= tick_next;
            btn_level_reg  <= btn_level_next;
            btn_change_reg <= btn_change_next;
            led_phase_reg  <= led_phase_next;
            led_drive_reg  <= led_drive_next;
            led_toggle_reg <= led_toggle_next;
            mode_reg       <= mode_next;
            save_slot_reg  <= save_slot_next;
            play_slot_reg  <= play_slot_next;
            play_step_reg  <= play_step_next;
            servo_reg      <= servo_next;
        end
    end

    // output register, refilled in the cycle the waiting word is taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_data_reg <= out_data_next;
        end
    end

endmodule

### sv/srpc_checker.sv
// srpc_checker: port-level checks on the controller's result stream
// depends on srpc_pkg; bound to servo_record_playback_controller_unit

module srpc_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             s_tvalid,
    input logic                             s_tready,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [srpc_pkg::OUT_TDATA_W-1:0] m_tdata
);
    import srpc_pkg::*;

    logic [1:0]         mode_f;
    logic [FLAGS_W-1:0] flags_f;
    logic [2:0]         next_f;

    assign mode_f  = m_tdata[OUT_MODE_LSB +: 2];
    assign flags_f = m_tdata[OUT_FLAGS_LSB +: FLAGS_W];
    assign next_f  = m_tdata[OUT_NEXT_LSB +: 3];

    // a held result word does not change
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed while stalled");

    // every accepted tick gives a result the next cycle
    a_result: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> m_tvalid)
        else $error("accepted tick gave no result");

    // saves and slot steps only happen in manual mode
    a_manual_events: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (flags_f[FLAG_SAVED] || flags_f[FLAG_SLOT]) |-> mode_f == MODE_CODE_MANUAL)
        else $error("save or slot step outside manual mode");

    // a restart leaves playback pointing at slot zero
    a_restart: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && flags_f[FLAG_RESTART] |-> mode_f == MODE_CODE_PLAY && next_f == 3'd0)
        else $error("restart did not return to slot zero");

    // staying in manual keeps the led lit
    a_led_manual: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && mode_f == MODE_CODE_MANUAL && !flags_f[FLAG_MODE] |-> m_tdata[OUT_LED_BIT])
        else $error("led dark in manual mode");

endmodule

bind servo_record_playback_controller_unit srpc_checker u_srpc_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
